// ===== hw/rtl/fibonacci_range_sum_modulo_top_macros.svh =====
// ----------------------------------------------------------------------------
// fibonacci_range_sum_modulo_top_macros
// Assertion macros shared by the checker of the range-sum block.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_RANGE_SUM_MODULO_TOP_MACROS_SVH
`define FIBONACCI_RANGE_SUM_MODULO_TOP_MACROS_SVH

// Antecedent this cycle, consequent in the next cycle.
`define FRSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent and consequent in the same cycle.
`define FRSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/frsm_pkg.sv =====
// ----------------------------------------------------------------------------
// frsm_pkg
// Widths, types, state encoding and control structs of the range-sum block.
// ----------------------------------------------------------------------------
package frsm_pkg;

	localparam int MAX_MODULUS   = 1024;
	localparam int MODULUS_RESET = 10;

	localparam int CFG_W  = 11;                          // modulus register
	localparam int IDX_W  = 60;                          // index fields
	localparam int SUM_W  = 10;                          // result field
	localparam int MOD_W  = $clog2(MAX_MODULUS + 1);     // effective modulus
	localparam int VAL_W  = $clog2(MAX_MODULUS);         // residues below m
	localparam int PER_W  = $clog2(6 * MAX_MODULUS + 1); // Pisano period <= 6m
	localparam int DIVD_W = IDX_W + 1;                   // index + 2
	localparam int RCNT_W = $clog2(DIVD_W);

	typedef logic [CFG_W-1:0]  cfg_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [MOD_W-1:0]  mod_t;
	typedef logic [MOD_W:0]    dw_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [VAL_W:0]    stp_t;
	typedef logic [PER_W-1:0]  per_t;
	typedef logic [PER_W:0]    pw_t;
	typedef logic [DIVD_W-1:0] divd_t;
	typedef logic [RCNT_W-1:0] rcnt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HI_GO,
		ST_HI_WAIT,
		ST_HI_WALK,
		ST_LO_GO,
		ST_LO_WAIT,
		ST_LO_WALK,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic load_in;
		logic search_step;
		logic rem_start;
		logic rem_sel_lo;
		logic walk_init;
		logic walk_step;
		logic cap_hi;
		logic cap_lo;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic mod_small;
		logic search_end;
		logic rem_done;
		logic walk_done;
	} sts_t;

endpackage

// ===== hw/rtl/frsm_rem.sv =====
// ----------------------------------------------------------------------------
// frsm_rem
// Bit-serial restoring remainder: wide index modulo the Pisano period.
// ----------------------------------------------------------------------------
module frsm_rem (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  frsm_pkg::divd_t dividend,
	input  frsm_pkg::per_t  divisor,
	output logic            done,
	output frsm_pkg::per_t  remainder
);

	logic            busy_q;
	logic            done_q;
	frsm_pkg::rcnt_t cnt_q;
	frsm_pkg::divd_t shift_q;
	frsm_pkg::per_t  rem_q;
	frsm_pkg::pw_t   trial;
	frsm_pkg::per_t  rem_d;

	always_comb begin
		trial = {rem_q, shift_q[frsm_pkg::DIVD_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_d = frsm_pkg::per_t'(trial - {1'b0, divisor});
		end else begin
			rem_d = trial[frsm_pkg::PER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= frsm_pkg::rcnt_t'(frsm_pkg::DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[frsm_pkg::DIVD_W-2:0], 1'b0};
			rem_q   <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/frsm_dp.sv =====
// ----------------------------------------------------------------------------
// frsm_dp
// Datapath: modulus register, recurrence step, period search, walks, result.
// ----------------------------------------------------------------------------
module frsm_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  frsm_pkg::cfg_t   cfg_wdata,
	input  frsm_pkg::idx_t   first_index,
	input  frsm_pkg::idx_t   last_index,
	input  frsm_pkg::cmd_t   cmd,
	output frsm_pkg::sts_t   sts,
	output frsm_pkg::sum_t   range_sum
);

	frsm_pkg::cfg_t  modulus_q;
	frsm_pkg::idx_t  first_q;
	frsm_pkg::idx_t  last_q;
	frsm_pkg::val_t  a_q;
	frsm_pkg::val_t  b_q;
	frsm_pkg::per_t  cnt_q;
	frsm_pkg::per_t  period_q;
	frsm_pkg::per_t  r_q;
	frsm_pkg::val_t  upper_q;
	frsm_pkg::val_t  lower_q;
	frsm_pkg::sum_t  range_sum_q;

	frsm_pkg::mod_t  m_eff;
	frsm_pkg::per_t  limit;
	frsm_pkg::stp_t  pair_sum;
	frsm_pkg::val_t  c_next;
	frsm_pkg::divd_t dividend;
	frsm_pkg::dw_t   diff;
	frsm_pkg::dw_t   diff_red;
	frsm_pkg::per_t  rem_val;
	logic            rem_done;

	// saturate the modulus at the largest served value
	always_comb begin
		if (32'(modulus_q) > frsm_pkg::MAX_MODULUS) begin
			m_eff = frsm_pkg::mod_t'(frsm_pkg::MAX_MODULUS);
		end else begin
			m_eff = frsm_pkg::mod_t'(modulus_q);
		end
	end

	assign limit = frsm_pkg::per_t'(m_eff) * frsm_pkg::per_t'(6);

	// one recurrence step: both terms are below m, so one subtract suffices
	always_comb begin
		pair_sum = {1'b0, a_q} + {1'b0, b_q};
		if (pair_sum >= frsm_pkg::stp_t'(m_eff)) begin
			c_next = frsm_pkg::val_t'(pair_sum - frsm_pkg::stp_t'(m_eff));
		end else begin
			c_next = pair_sum[frsm_pkg::VAL_W-1:0];
		end
	end

	assign dividend = cmd.rem_sel_lo ? ({1'b0, first_q} + frsm_pkg::divd_t'(1))
	                                 : ({1'b0, last_q} + frsm_pkg::divd_t'(2));

	// upper + m - lower lies in (0, 2m)
	always_comb begin
		diff = frsm_pkg::dw_t'(upper_q) + frsm_pkg::dw_t'(m_eff) - frsm_pkg::dw_t'(lower_q);
		if (diff >= frsm_pkg::dw_t'(m_eff)) begin
			diff_red = diff - frsm_pkg::dw_t'(m_eff);
		end else begin
			diff_red = diff;
		end
	end

	frsm_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.rem_start),
		.dividend  (dividend),
		.divisor   (period_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= frsm_pkg::cfg_t'(frsm_pkg::MODULUS_RESET);
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			first_q <= first_index;
			last_q  <= last_index;
		end
		if (cmd.load_in || cmd.walk_init) begin
			a_q <= '0;
			b_q <= frsm_pkg::val_t'(1);
		end else if (cmd.search_step || cmd.walk_step) begin
			a_q <= b_q;
			b_q <= c_next;
		end
		if (cmd.load_in) begin
			cnt_q <= frsm_pkg::per_t'(1);
		end else if (cmd.walk_init) begin
			cnt_q <= '0;
		end else if (cmd.search_step || cmd.walk_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.search_step && sts.search_end) begin
			period_q <= cnt_q;
		end
		if (cmd.walk_init) begin
			r_q <= rem_val;
		end
		if (cmd.cap_hi) begin
			upper_q <= a_q;
		end
		if (cmd.cap_lo) begin
			lower_q <= a_q;
		end
		if (cmd.load_out) begin
			range_sum_q <= sts.mod_small ? '0 : frsm_pkg::sum_t'(diff_red);
		end
	end

	always_comb begin
		sts.mod_small  = m_eff < frsm_pkg::mod_t'(2);
		sts.search_end = ((b_q == '0) && (c_next == frsm_pkg::val_t'(1))) || (cnt_q == limit);
		sts.rem_done   = rem_done;
		sts.walk_done  = cnt_q == r_q;
	end

	assign range_sum = range_sum_q;

endmodule

// ===== hw/rtl/frsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frsm_ctrl
// Controller: sequences search, reductions and walks; owns the handshakes.
// ----------------------------------------------------------------------------
module frsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  frsm_pkg::sts_t sts,
	output frsm_pkg::cmd_t cmd
);

	frsm_pkg::state_t state_q;
	frsm_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frsm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.mod_small ? frsm_pkg::ST_DELIVER : frsm_pkg::ST_SEARCH;
				end
			end
			frsm_pkg::ST_SEARCH: begin
				if (sts.search_end) begin
					state_d = frsm_pkg::ST_HI_GO;
				end
			end
			frsm_pkg::ST_HI_GO:   state_d = frsm_pkg::ST_HI_WAIT;
			frsm_pkg::ST_HI_WAIT: begin
				if (sts.rem_done) begin
					state_d = frsm_pkg::ST_HI_WALK;
				end
			end
			frsm_pkg::ST_HI_WALK: begin
				if (sts.walk_done) begin
					state_d = frsm_pkg::ST_LO_GO;
				end
			end
			frsm_pkg::ST_LO_GO:   state_d = frsm_pkg::ST_LO_WAIT;
			frsm_pkg::ST_LO_WAIT: begin
				if (sts.rem_done) begin
					state_d = frsm_pkg::ST_LO_WALK;
				end
			end
			frsm_pkg::ST_LO_WALK: begin
				if (sts.walk_done) begin
					state_d = frsm_pkg::ST_DELIVER;
				end
			end
			frsm_pkg::ST_DELIVER: begin
				if (out_free) begin
					state_d = frsm_pkg::ST_IDLE;
				end
			end
			default: state_d = frsm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			frsm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			frsm_pkg::ST_SEARCH:  cmd.search_step = 1'b1;
			frsm_pkg::ST_HI_GO:   cmd.rem_start   = 1'b1;
			frsm_pkg::ST_HI_WAIT: cmd.walk_init   = sts.rem_done;
			frsm_pkg::ST_HI_WALK: begin
				cmd.cap_hi    = sts.walk_done;
				cmd.walk_step = !sts.walk_done;
			end
			frsm_pkg::ST_LO_GO: begin
				cmd.rem_start  = 1'b1;
				cmd.rem_sel_lo = 1'b1;
			end
			frsm_pkg::ST_LO_WAIT: cmd.walk_init = sts.rem_done;
			frsm_pkg::ST_LO_WALK: begin
				cmd.cap_lo    = sts.walk_done;
				cmd.walk_step = !sts.walk_done;
			end
			frsm_pkg::ST_DELIVER: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frsm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/fibonacci_range_sum_modulo_top.sv =====
// Per transaction: a search for the Pisano period p of m, then for each index in turn its
// reduction modulo p (r_hi, r_lo) and a recurrence walk to that reduced index.
// The period search and the two recurrence walks share one step unit; they and the two bit-serial
// remainders run one after another, and a modulus below 2 skips them all.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: arst_n clears the controller and output valid and sets the modulus to 10.
// ----------------------------------------------------------------------------
// fibonacci_range_sum_modulo_top
// Sum of Fibonacci terms F(first..last) modulo a programmable modulus.
// ----------------------------------------------------------------------------
module fibonacci_range_sum_modulo_top (
	input  logic           clk,
	input  logic           arst_n,
	// configuration: modulus register, write-only
	input  logic           cfg_we,
	input  frsm_pkg::cfg_t cfg_wdata,
	// input transaction
	input  logic           in_valid,
	output logic           in_ready,
	input  frsm_pkg::idx_t first_index,
	input  frsm_pkg::idx_t last_index,
	// result transaction
	output logic           out_valid,
	input  logic           out_ready,
	output frsm_pkg::sum_t range_sum
);

	// Sum F(0..n) = F(n+2) - 1, so the result is F(last+2) - F(first+1) mod m.
	// Sequence per transaction:
	//   search  - step (0,1) until the pair comes back, giving the period p
	//   hi      - (last+2) mod p in the remainder unit, then walk that many steps
	//   lo      - (first+1) mod p likewise
	//   deliver - upper + m - lower, one compare-subtract, into the output register
	// A reversed range just yields the formula value; a modulus above the
	// maximum saturates, and one below 2 gives 0 without running the search.

	frsm_pkg::cmd_t cmd;
	frsm_pkg::sts_t sts;

	frsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// the result stays in the output register until taken; the next
	// transaction is accepted meanwhile and waits only at delivery
	frsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.first_index (first_index),
		.last_index  (last_index),
		.cmd         (cmd),
		.sts         (sts),
		.range_sum   (range_sum)
	);

endmodule

// ===== hw/rtl/frsm_checker.sv =====
// ----------------------------------------------------------------------------
// frsm_checker
// Port-level assertions for the range-sum block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fibonacci_range_sum_modulo_top_macros.svh"

module frsm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input frsm_pkg::sum_t range_sum
);

	// stalled result holds
	`FRSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(range_sum), "stalled result changed")

	// one transaction in flight: busy straight after acceptance
	`FRSM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after acceptance")

	// a result is never produced in the cycle right after acceptance
	`FRSM_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid), "result too early")

	// a new result only appears while the block was busy
	`FRSM_ASSERT_NOW(a_out_from_busy, $rose(out_valid), !$past(in_ready), "result while idle")

endmodule

bind fibonacci_range_sum_modulo_top frsm_checker u_frsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.range_sum (range_sum)
);
